/* rtl/vies_pkg.sv */
// shared types, constants and saturating helpers for the euler step block
package vies_pkg;

   localparam int FRAC_BITS = 32;
   localparam int NUM_REGS  = 8;
   localparam int REG_W     = 63;
   localparam int IDX_W     = $clog2(NUM_REGS);
   localparam int REQ_W     = 192;
   localparam int RSP_W     = 208;

   localparam logic [IDX_W-1:0] REG_SOURCE_RATE    = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_TARGET_DECAY   = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_INFECTION_RATE = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_KILL_RATE      = IDX_W'(3);
   localparam logic [IDX_W-1:0] REG_INFECTED_DECAY = IDX_W'(4);
   localparam logic [IDX_W-1:0] REG_IMMUNE_GROWTH  = IDX_W'(5);
   localparam logic [IDX_W-1:0] REG_IMMUNE_DECAY   = IDX_W'(6);
   localparam logic [IDX_W-1:0] REG_TIME_STEP      = IDX_W'(7);

   localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;

   localparam logic [REG_W-1:0] SOURCE_RATE_RST    = REG_W'(64'd50000 << FRAC_BITS);
   localparam logic [REG_W-1:0] TARGET_DECAY_RST   = REG_W'(ONE_FX);
   localparam logic [REG_W-1:0] INFECTION_RATE_RST = REG_W'((ONE_FX + 64'd2000) / 64'd4000);
   localparam logic [REG_W-1:0] KILL_RATE_RST      = REG_W'((ONE_FX + 64'd10000) / 64'd20000);
   localparam logic [REG_W-1:0] INFECTED_DECAY_RST = REG_W'(64'd5 << FRAC_BITS);
   localparam logic [REG_W-1:0] IMMUNE_GROWTH_RST  = REG_W'(64'd10 << FRAC_BITS);
   localparam logic [REG_W-1:0] IMMUNE_DECAY_RST   = REG_W'(64'd5 << FRAC_BITS);
   localparam logic [REG_W-1:0] TIME_STEP_RST      = REG_W'((ONE_FX + 64'd50) / 64'd100);

   localparam logic signed [63:0] FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] FX_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] value;
   } mul_rsp_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if ((a[63] == b[63]) && (s[63] != a[63])) begin
         return a[63] ? FX_MIN : FX_MAX;
      end
      return s;
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if ((a[63] != b[63]) && (s[63] != a[63])) begin
         return a[63] ? FX_MIN : FX_MAX;
      end
      return s;
   endfunction

endpackage

/* rtl/vies_mul.sv */
// shared saturating fixed-point multiplier, one 32x32 partial product per cycle
module vies_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  vies_pkg::mul_cmd_type cmd,
   output vies_pkg::mul_rsp_type rsp
);
   import vies_pkg::*;

   localparam logic [2:0] LAST_ISSUE = 3'd3;
   localparam logic [2:0] LAST_CNT   = 3'd5;

   logic         busy_ff, busy_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         neg_ff, neg_in;
   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic [63:0]  prod_ff, prod_in;
   logic         pv_ff, pv_in;
   logic [1:0]   psel_ff, psel_in;
   logic [127:0] acc_ff, acc_in;
   logic         done_ff, done_in;
   logic signed [63:0] res_ff, res_in;

   logic [31:0]  opa, opb;
   logic [127:0] addend;
   logic         ovf;
   logic [63:0]  q;

   always_comb begin
      opa    = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      opb    = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      prod_in = {32'd0, opa} * {32'd0, opb};
      unique case (psel_ff)
         2'd0:    addend = {64'd0, prod_ff};
         2'd3:    addend = {prod_ff, 64'd0};
         default: addend = {32'd0, prod_ff, 32'd0};
      endcase
      ovf = |acc_ff[127:64+FRAC_BITS];
      q   = acc_ff[64+FRAC_BITS-1:FRAC_BITS];
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      pv_in   = 1'b0;
      psel_in = cnt_ff[1:0];
      done_in = 1'b0;
      res_in  = res_ff;
      if (!busy_ff) begin
         if (cmd.start) begin
            busy_in = 1'b1;
            cnt_in  = 3'd0;
            neg_in  = cmd.a[63] ^ cmd.b[63];
            ma_in   = cmd.a[63] ? ~cmd.a + 64'd1 : cmd.a;
            mb_in   = cmd.b[63] ? ~cmd.b + 64'd1 : cmd.b;
            acc_in  = '0;
         end
      end else begin
         pv_in = (cnt_ff <= LAST_ISSUE);
         if (pv_ff) begin
            acc_in = acc_ff + addend;
         end
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               res_in = (ovf || q[63]) ? FX_MIN : ~q + 64'd1;
            end else begin
               res_in = (ovf || q[63]) ? FX_MAX : q;
            end
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         pv_ff   <= pv_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      prod_ff <= prod_in;
      psel_ff <= psel_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

/* rtl/virus_immune_euler_step.sv */
// forward euler step for the target / infected / immune cell model
// load request: result valid in the cycle after accept
// step request: 11 products in turn through one shared multiplier, each built from the
//   multiplier's 4 partial products per 64-bit product; result valid after the last one
// one request in flight; req_tready is low from accept until the result is taken
// synchronous active-high reset: state and step count to zero, rate registers to defaults
module virus_immune_euler_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // init_target, init_infected, init_immune
   input  logic [vies_pkg::REQ_W-1:0]  req_tdata,
   // action
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // step_index, target_out, infected_out, immune_out
   output logic [vies_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_we,
   input  logic [vies_pkg::IDX_W-1:0]  csr_index,
   input  logic [vies_pkg::REG_W-1:0]  csr_wdata
);
   import vies_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   localparam logic [3:0] OP_IR_X   = 4'd0;
   localparam logic [3:0] OP_INF    = 4'd1;
   localparam logic [3:0] OP_TD_X   = 4'd2;
   localparam logic [3:0] OP_KR_W   = 4'd3;
   localparam logic [3:0] OP_KILL   = 4'd4;
   localparam logic [3:0] OP_ID_Y   = 4'd5;
   localparam logic [3:0] OP_IG_Y   = 4'd6;
   localparam logic [3:0] OP_IDC_W  = 4'd7;
   localparam logic [3:0] OP_DX_DT  = 4'd8;
   localparam logic [3:0] OP_DY_DT  = 4'd9;
   localparam logic [3:0] OP_DW_DT  = 4'd10;

   localparam logic [REG_W-1:0] CFG_RST [NUM_REGS] = '{
      SOURCE_RATE_RST, TARGET_DECAY_RST, INFECTION_RATE_RST, KILL_RATE_RST,
      INFECTED_DECAY_RST, IMMUNE_GROWTH_RST, IMMUNE_DECAY_RST, TIME_STEP_RST};

   logic [REG_W-1:0] cfg_ff [NUM_REGS];

   logic [1:0]  state_ff, state_in;
   logic [3:0]  op_ff, op_in;
   logic        rvalid_ff, rvalid_in;
   logic [15:0] count_ff, count_in;
   logic signed [63:0] x_ff, x_in, y_ff, y_in, w_ff, w_in;
   logic signed [63:0] tmp_ff, tmp_in, inf_ff, inf_in;
   logic signed [63:0] dx_ff, dx_in, dy_ff, dy_in, dw_ff, dw_in;

   mul_cmd_type mcmd;
   mul_rsp_type mrsp;
   logic signed [63:0] r;

   function automatic logic signed [63:0] cfg_val(input logic [REG_W-1:0] v);
      return {1'b0, v};
   endfunction

   vies_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mcmd),
      .rsp   (mrsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= CFG_RST[i];
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // operand select per product
   always_comb begin
      mcmd.start = (state_ff == ST_ISSUE);
      unique case (op_ff)
         OP_IR_X:  begin mcmd.a = cfg_val(cfg_ff[REG_INFECTION_RATE]); mcmd.b = x_ff; end
         OP_INF:   begin mcmd.a = tmp_ff; mcmd.b = y_ff; end
         OP_TD_X:  begin mcmd.a = cfg_val(cfg_ff[REG_TARGET_DECAY]); mcmd.b = x_ff; end
         OP_KR_W:  begin mcmd.a = cfg_val(cfg_ff[REG_KILL_RATE]); mcmd.b = w_ff; end
         OP_KILL:  begin mcmd.a = tmp_ff; mcmd.b = y_ff; end
         OP_ID_Y:  begin mcmd.a = cfg_val(cfg_ff[REG_INFECTED_DECAY]); mcmd.b = y_ff; end
         OP_IG_Y:  begin mcmd.a = cfg_val(cfg_ff[REG_IMMUNE_GROWTH]); mcmd.b = y_ff; end
         OP_IDC_W: begin mcmd.a = cfg_val(cfg_ff[REG_IMMUNE_DECAY]); mcmd.b = w_ff; end
         OP_DX_DT: begin mcmd.a = dx_ff; mcmd.b = cfg_val(cfg_ff[REG_TIME_STEP]); end
         OP_DY_DT: begin mcmd.a = dy_ff; mcmd.b = cfg_val(cfg_ff[REG_TIME_STEP]); end
         OP_DW_DT: begin mcmd.a = dw_ff; mcmd.b = cfg_val(cfg_ff[REG_TIME_STEP]); end
         default:  begin mcmd.a = '0; mcmd.b = '0; end
      endcase
   end

   assign r = mrsp.value;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      rvalid_in = rvalid_ff;
      count_in  = count_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      w_in      = w_ff;
      tmp_in    = tmp_ff;
      inf_in    = inf_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dw_in     = dw_ff;
      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (!req_tuser) begin
                  x_in      = req_tdata[63:0];
                  y_in      = req_tdata[127:64];
                  w_in      = req_tdata[191:128];
                  count_in  = '0;
                  rvalid_in = 1'b1;
               end else begin
                  op_in    = OP_IR_X;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mrsp.done) begin
               op_in    = op_ff + 4'd1;
               state_in = ST_ISSUE;
               unique case (op_ff)
                  OP_IR_X:  tmp_in = r;
                  OP_INF:   inf_in = r;
                  OP_TD_X:  dx_in = sat_sub(cfg_val(cfg_ff[REG_SOURCE_RATE]), r);
                  OP_KR_W:  begin
                     tmp_in = r;
                     dx_in  = sat_sub(dx_ff, inf_ff);
                  end
                  OP_KILL:  dy_in = sat_sub(inf_ff, r);
                  OP_ID_Y:  dy_in = sat_sub(dy_ff, r);
                  OP_IG_Y:  dw_in = r;
                  OP_IDC_W: dw_in = sat_sub(dw_ff, r);
                  OP_DX_DT: x_in = sat_add(x_ff, r);
                  OP_DY_DT: y_in = sat_add(y_ff, r);
                  OP_DW_DT: begin
                     w_in      = sat_add(w_ff, r);
                     count_in  = count_ff + 16'd1;
                     rvalid_in = 1'b1;
                     state_in  = ST_IDLE;
                  end
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         op_ff     <= OP_IR_X;
         rvalid_ff <= 1'b0;
         count_ff  <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         w_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         rvalid_ff <= rvalid_in;
         count_ff  <= count_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         w_ff      <= w_in;
      end
      tmp_ff <= tmp_in;
      inf_ff <= inf_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      dw_ff  <= dw_in;
   end

   assign req_tready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {w_ff, y_ff, x_ff, count_ff};

endmodule

/* rtl/vies_checker.sv */
// port-level checks for the euler step block, bound to the top level
module vies_props (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [vies_pkg::REQ_W-1:0] req_tdata,
   input logic                       req_tuser,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [vies_pkg::RSP_W-1:0] rsp_tdata
);
   import vies_pkg::*;

   // one request in flight: never ready while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("ready while result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed under stall");

   // load answers next cycle with count cleared and the loaded state
   a_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=>
         rsp_tvalid && (rsp_tdata[15:0] == 16'd0) &&
         (rsp_tdata[RSP_W-1:16] == $past(req_tdata)))
      else $error("load result wrong");

   // a step needs many multiplier passes
   a_step_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("step result too early");

endmodule

bind virus_immune_euler_step vies_props u_vies_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/euler_tb_pkg.sv */
// action codes and default rate values shared by the euler step testbench
package euler_tb_pkg;

   localparam int FRAC = vies_pkg::FRAC_BITS;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_STEP = 1'b1
   } action_type;

   // rate register values that hold after reset
   function automatic logic [vies_pkg::REG_W-1:0] default_rate(
         input logic [vies_pkg::IDX_W-1:0] idx);
      logic [63:0] v;
      case (idx)
         vies_pkg::REG_SOURCE_RATE:    v = 64'd50000 << FRAC;
         vies_pkg::REG_TARGET_DECAY:   v = 64'd1 << FRAC;
         vies_pkg::REG_INFECTION_RATE: v = ((64'd1 << FRAC) + 64'd2000) / 64'd4000;
         vies_pkg::REG_KILL_RATE:      v = ((64'd1 << FRAC) + 64'd10000) / 64'd20000;
         vies_pkg::REG_INFECTED_DECAY: v = 64'd5 << FRAC;
         vies_pkg::REG_IMMUNE_GROWTH:  v = 64'd10 << FRAC;
         vies_pkg::REG_IMMUNE_DECAY:   v = 64'd5 << FRAC;
         default:                      v = ((64'd1 << FRAC) + 64'd50) / 64'd100;
      endcase
      return v[vies_pkg::REG_W-1:0];
   endfunction

endpackage

/* bench/vies_checker.sv */
// population predictor and result checker for the euler step block
module vies_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   // init_target, init_infected, init_immune
   input  logic [vies_pkg::REQ_W-1:0]  req_tdata,
   // action
   input  logic                        req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // step_index, target_out, infected_out, immune_out
   input  logic [vies_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_we,
   input  logic [vies_pkg::IDX_W-1:0]  csr_index,
   input  logic [vies_pkg::REG_W-1:0]  csr_wdata,
   output int                          error_count,
   output int                          pending,
   output int                          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import euler_tb_pkg::*;

   localparam logic signed [63:0] SAT_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SAT_LO = 64'sh8000_0000_0000_0000;

   // same layout as rsp_tdata, step count in the lowest bits
   typedef struct packed {
      logic signed [63:0] immune;
      logic signed [63:0] infected;
      logic signed [63:0] target;
      logic [15:0]        count;
   } population_type;

   logic signed [63:0] rates [vies_pkg::NUM_REGS];
   population_type     model_state;
   population_type     expected_populations [$];
   population_type     want;
   population_type     got;
   logic [63:0]        want_f [4];
   logic [63:0]        got_f [4];
   string              field_tags [4] = '{"step_index", "target_out", "infected_out",
                                          "immune_out"};
   int                 errs;
   int                 checked;

   function automatic logic signed [63:0] fx_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? SAT_LO : SAT_HI;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] fx_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? SAT_LO : SAT_HI;
      return s[63:0];
   endfunction

   // exact product, magnitude truncated by FRAC bits, then clamped
   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] prod;
      logic [127:0] q;
      logic         neg;
      neg  = a[63] ^ b[63];
      ma   = a[63] ? (~a + 64'd1) : a;
      mb   = b[63] ? (~b + 64'd1) : b;
      prod = {64'd0, ma} * {64'd0, mb};
      q    = prod >> FRAC;
      if (neg) begin
         if (q >= 128'h8000_0000_0000_0000) return SAT_LO;
         return ~q[63:0] + 64'd1;
      end
      if (q > 128'h7FFF_FFFF_FFFF_FFFF) return SAT_HI;
      return q[63:0];
   endfunction

   function automatic population_type advance_populations(input population_type s);
      population_type     n;
      logic signed [63:0] infection;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [63:0] dw;
      logic signed [63:0] dt;
      dt = rates[vies_pkg::REG_TIME_STEP];
      infection = fx_mul(fx_mul(rates[vies_pkg::REG_INFECTION_RATE], s.target), s.infected);
      dx = fx_sub(fx_sub(rates[vies_pkg::REG_SOURCE_RATE],
                         fx_mul(rates[vies_pkg::REG_TARGET_DECAY], s.target)), infection);
      dy = fx_sub(fx_sub(infection,
                         fx_mul(fx_mul(rates[vies_pkg::REG_KILL_RATE], s.immune), s.infected)),
                  fx_mul(rates[vies_pkg::REG_INFECTED_DECAY], s.infected));
      dw = fx_sub(fx_mul(rates[vies_pkg::REG_IMMUNE_GROWTH], s.infected),
                  fx_mul(rates[vies_pkg::REG_IMMUNE_DECAY], s.immune));
      n.target   = fx_add(s.target, fx_mul(dx, dt));
      n.infected = fx_add(s.infected, fx_mul(dy, dt));
      n.immune   = fx_add(s.immune, fx_mul(dw, dt));
      n.count    = s.count + 16'd1;
      return n;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vies_pkg::NUM_REGS; i++) begin
            rates[i] = {1'b0, default_rate(vies_pkg::IDX_W'(i))};
         end
         model_state = '0;
         expected_populations.delete();
         errs = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            rates[csr_index] = {1'b0, csr_wdata};
         end
         if (req_tvalid && req_tready) begin
            if (action_type'(req_tuser) == ACT_LOAD) begin
               model_state.target   = req_tdata[63:0];
               model_state.infected = req_tdata[127:64];
               model_state.immune   = req_tdata[191:128];
               model_state.count    = '0;
            end else begin
               model_state = advance_populations(model_state);
            end
            expected_populations.push_back(model_state);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = population_type'(rsp_tdata);
            if (expected_populations.size() == 0) begin
               $display("%0t: result with no request pending, got %h", $time, rsp_tdata);
               errs++;
            end else begin
               want = expected_populations.pop_front();
               checked++;
               want_f = '{64'(want.count), want.target, want.infected, want.immune};
               got_f  = '{64'(got.count), got.target, got.infected, got.immune};
               for (int f = 0; f < 4; f++) begin
                  if (want_f[f] !== got_f[f]) begin
                     $display("%0t: %s mismatch, expected %h, got %h",
                              $time, field_tags[f], want_f[f], got_f[f]);
                     errs++;
                  end
               end
            end
         end
      end
      error_count     <= errs;
      pending         <= expected_populations.size();
      results_checked <= checked;
   end

endmodule

/* bench/tb_top.sv */
// stimulus and verdict for the euler step block
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import euler_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int ITEMS_PER_SET = 170;
   localparam int SETTLE_CYCLES = 100;

   typedef enum int {
      SET_DEFAULT,
      SET_MAX,
      SET_ZERO,
      SET_TYPICAL,
      SET_WIDE
   } rate_set_type;

   localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [vies_pkg::REQ_W-1:0]  req_tdata = '0;
   logic                        req_tuser = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [vies_pkg::RSP_W-1:0]  rsp_tdata;
   logic                        csr_we = 1'b0;
   logic [vies_pkg::IDX_W-1:0]  csr_index = '0;
   logic [vies_pkg::REG_W-1:0]  csr_wdata = '0;

   logic steady = 1'b0;
   int   cycle_count = 0;
   int   error_count;
   int   pending;
   int   results_checked;
   int   loads_sent = 0;
   int   steps_sent = 0;
   int   settings_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   virus_immune_euler_step u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   vies_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 19);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // mix of extremes, full-range words and plausible cell counts
   function automatic logic [63:0] pick_population();
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0: v = VAL_MAX;
         1: v = VAL_MIN;
         2: v = '0;
         3, 4, 5: v = {$urandom, $urandom};
         default: begin
            v = (64'($urandom_range(0, 100000)) << FRAC) | 64'($urandom);
            if ($urandom_range(0, 3) == 0) v = ~v + 64'd1;
         end
      endcase
      return v;
   endfunction

   task automatic send_request(input action_type act, input logic [63:0] x,
                               input logic [63:0] y, input logic [63:0] w);
      if (!steady) begin
         while ($urandom_range(0, 99) < 19) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {w, y, x};
      do @(posedge clock); while (!req_tready);
      if (act == ACT_LOAD) loads_sent++;
      else steps_sent++;
   endtask

   task automatic load_and_step(input logic [63:0] x, input logic [63:0] y,
                                input logic [63:0] w, input int steps);
      send_request(ACT_LOAD, x, y, w);
      for (int i = 0; i < steps; i++) begin
         // init fields are don't-care on a step, keep them noisy
         send_request(ACT_STEP, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom});
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic program_rates(input rate_set_type set_kind);
      logic [62:0] v;
      for (int i = 0; i < vies_pkg::NUM_REGS; i++) begin
         case (set_kind)
            SET_DEFAULT: v = default_rate(vies_pkg::IDX_W'(i));
            SET_MAX:     v = '1;
            SET_ZERO:    v = '0;
            SET_WIDE:    v = 63'({$urandom, $urandom});
            default: begin
               if (vies_pkg::IDX_W'(i) == vies_pkg::REG_TIME_STEP)
                  v = 63'($urandom_range(0, 32'h0800_0000));
               else if (vies_pkg::IDX_W'(i) == vies_pkg::REG_SOURCE_RATE)
                  v = (63'($urandom_range(0, 100000)) << FRAC) | 63'($urandom);
               else
                  v = (63'($urandom_range(0, 20)) << FRAC) | 63'($urandom);
            end
         endcase
         csr_we    <= 1'b1;
         csr_index <= vies_pkg::IDX_W'(i);
         csr_wdata <= v;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic random_run(input int count);
      int start;
      start = loads_sent + steps_sent;
      while (loads_sent + steps_sent - start < count) begin
         case ($urandom_range(0, 9))
            // stray step continuing from whatever state is held
            0: send_request(ACT_STEP, {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom});
            // back-to-back loads
            1: load_and_step(pick_population(), pick_population(), pick_population(), 0);
            default: load_and_step(pick_population(), pick_population(), pick_population(),
                                   $urandom_range(1, 25));
         endcase
         if (steady && (loads_sent + steps_sent - start >= 150)) steady <= 1'b0;
      end
   endtask

   initial begin
      rate_set_type plan [6] = '{SET_TYPICAL, SET_MAX, SET_ZERO, SET_WIDE, SET_TYPICAL,
                                 SET_DEFAULT};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset rate values, stepping from the all-zero state first
      send_request(ACT_STEP, '0, '0, '0);
      send_request(ACT_STEP, VAL_MAX, VAL_MIN, VAL_MAX);
      load_and_step(64'd10000 << FRAC, 64'd100 << FRAC, 64'd10 << FRAC, 5);
      load_and_step(VAL_MAX, VAL_MAX, VAL_MAX, 1);
      load_and_step(VAL_MIN, VAL_MIN, VAL_MIN, 1);
      load_and_step(VAL_MAX, VAL_MIN, VAL_MAX, 1);
      load_and_step(VAL_MIN, VAL_MAX, VAL_MIN, 1);
      load_and_step(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1);
      load_and_step('0, '0, '0, 1);

      for (int p = 0; p < 6; p++) begin
         drain();
         program_rates(plan[p]);
         if (p == 0) steady <= 1'b1;
         random_run(ITEMS_PER_SET);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d loads and %0d steps across %0d rate settings", loads_sent, steps_sent,
               settings_used);
      $display("checked %0d results in %0d cycles", results_checked, cycle_count);
      if (error_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
